// File: sv/jsos_pkg.sv
// shared types and constants of the json segment offset scanner
package jsos_pkg;

  localparam int unsigned StatW  = 3;
  localparam int unsigned ValueW = 64;

  typedef enum logic [StatW-1:0] {
    ST_FOUND      = 3'd0,
    ST_NO_SEGKEY  = 3'd1,
    ST_NO_OFFKEY  = 3'd2,
    ST_NO_DIGITS  = 3'd3,
    ST_TOO_MANY   = 3'd4
  } status_e;

  typedef struct packed {
    status_e               status;
    logic [ValueW-1:0]     offset_value;
  } res_t;

endpackage

// File: sv/jsos_if.sv
// stream interfaces for the byte input and the result output
interface jsos_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface jsos_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] offset_value;

  modport source (output valid, output status, output offset_value, input ready);
  modport sink   (input valid, input status, input offset_value, output ready);
endinterface

// File: sv/json_segment_offset_scanner_core.sv
// top level of the json segment offset scanner
//  channel | dir | payload                 | transfer
//  in_i    | in  | byte_value, last_byte   | in_i.valid & in_i.ready
//  out_o   | out | status, offset_value    | out_o.valid & out_o.ready
// one byte is taken per cycle while no held result stalls a last byte; a byte
// goes from the input register through the scan logic, and a result is
// registered for output when its last byte leaves the input register
// reset clears the scan state and both stage valids; no result is emitted for
// an area cut short by reset
// a held result stalls only a last byte and the bytes behind it; other bytes keep flowing
module json_segment_offset_scanner_core #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  jsos_in_if.sink            in_i,
  jsos_out_if.source         out_o
);
  import jsos_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        last_q;
  logic        out_valid_q;
  res_t        out_q;
  res_t        res;
  logic        out_free;
  logic        step;

  assign out_free   = !out_valid_q || out_o.ready;
  assign step       = in_valid_q && (!last_q || out_free);
  assign in_i.ready = !in_valid_q || step;

  jsos_scan #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .last_i (last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.byte_value;
      last_q <= in_i.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_q) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_q.status;
  assign out_o.offset_value = out_q.offset_value;

endmodule

// File: sv/jsos_scan.sv
// scan state and per-byte next-state logic with result forming
module jsos_scan #(
  parameter int unsigned MAX_DIGITS = 19
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  logic [7:0]         byte_i,
  input  logic               last_i,
  output jsos_pkg::res_t     res_o
);
  import jsos_pkg::*;

  localparam int unsigned CntW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned SegLen = 10;
  localparam int unsigned OffLen = 8;

  localparam logic [7:0] KeySeg [SegLen] = '{
    8'h22, 8'h73, 8'h65, 8'h67, 8'h6d, 8'h65, 8'h6e, 8'h74, 8'h73, 8'h22};
  localparam logic [7:0] KeyOff [OffLen] = '{
    8'h22, 8'h6f, 8'h66, 8'h66, 8'h73, 8'h65, 8'h74, 8'h22};

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  typedef enum logic [2:0] {
    PH_SEGMENTS = 3'd0,
    PH_OFFSET   = 3'd1,
    PH_SKIP     = 3'd2,
    PH_DIGITS   = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [3:0]          match_q, match_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ValueW-1:0]   acc_q, acc_d;
  status_e             dec_q, dec_d;

  logic                is_digit;
  logic                is_sep;
  logic [3:0]          pos;
  logic [7:0]          key_ch;
  logic [3:0]          key_len;
  logic [ValueW-1:0]   acc_next;
  status_e             st;

  assign is_digit = (byte_i >= ChZero) && (byte_i <= ChNine);
  assign is_sep   = (byte_i == ChSpace) || (byte_i == ChColon) || (byte_i == ChQuote);
  assign acc_next = {acc_q[ValueW-4:0], 3'b000} + {acc_q[ValueW-2:0], 1'b0}
                  + {{(ValueW-4){1'b0}}, byte_i[3:0]};

  always_comb begin
    key_len = (phase_q == PH_SEGMENTS) ? 4'(SegLen) : 4'(OffLen);
    pos     = (match_q >= key_len) ? 4'd0 : match_q;
    key_ch  = (phase_q == PH_SEGMENTS) ? KeySeg[pos] : KeyOff[pos[2:0]];
  end

  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    count_d = count_q;
    acc_d   = acc_q;
    dec_d   = dec_q;
    unique case (phase_q)
      PH_SEGMENTS, PH_OFFSET: begin
        if (byte_i == key_ch) begin
          if (pos + 4'd1 == key_len) begin
            match_d = 4'd0;
            phase_d = (phase_q == PH_SEGMENTS) ? PH_OFFSET : PH_SKIP;
          end else begin
            match_d = pos + 4'd1;
          end
        end else begin
          match_d = (byte_i == ChQuote) ? 4'd1 : 4'd0;
        end
      end
      PH_SKIP, PH_DIGITS: begin
        if (!(phase_q == PH_SKIP && is_sep)) begin
          if (is_digit) begin
            if (count_q >= CntW'(MAX_DIGITS)) begin
              phase_d = PH_DONE;
              dec_d   = ST_TOO_MANY;
            end else begin
              acc_d   = acc_next;
              count_d = count_q + 1'b1;
              phase_d = PH_DIGITS;
            end
          end else begin
            phase_d = PH_DONE;
            dec_d   = (count_q == '0) ? ST_NO_DIGITS : ST_FOUND;
          end
        end
      end
      PH_DONE: ;
      default: ;
    endcase
  end

  always_comb begin
    unique case (phase_d)
      PH_SEGMENTS: st = ST_NO_SEGKEY;
      PH_OFFSET:   st = ST_NO_OFFKEY;
      PH_SKIP:     st = ST_NO_DIGITS;
      PH_DIGITS:   st = (count_d == '0) ? ST_NO_DIGITS : ST_FOUND;
      default:     st = dec_d;
    endcase
    res_o.status       = st;
    res_o.offset_value = (st == ST_FOUND) ? acc_d : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEGMENTS;
      match_q <= '0;
      count_q <= '0;
      acc_q   <= '0;
      dec_q   <= ST_FOUND;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PH_SEGMENTS;
        match_q <= '0;
        count_q <= '0;
        acc_q   <= '0;
        dec_q   <= ST_FOUND;
      end else begin
        phase_q <= phase_d;
        match_q <= match_d;
        count_q <= count_d;
        acc_q   <= acc_d;
        dec_q   <= dec_d;
      end
    end
  end

endmodule
